### rtl/core/ffha_pkg.sv
// Package for the first-fit heap allocator: payload words, codes, controller states,
// datapath operations and the status group returned to the controller.
// No dependencies.
`default_nettype none
package ffha_pkg;

  localparam int HEAP_BYTES_DEF = 4096;
  localparam int ALIGN_BYTES    = 4;
  localparam int HDR_BYTES      = 12;
  localparam int HDR_WORDS      = HDR_BYTES / ALIGN_BYTES;
  localparam int REGION_RESET   = 4096;
  localparam int MIN_REGION_W   = 8;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_USAGE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_OOM      = 2'd1,
    STAT_BAD_FREE = 2'd2
  } stat_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [12:0] request_size;
    logic [11:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] block_address;
    logic [12:0] used_bytes;
    logic [12:0] free_bytes;
  } out_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_INIT_HEAD,
    S_INIT_END,
    S_IDLE,
    S_A_CHK,
    S_A_RNX,
    S_A_WNX,
    S_A_WNODE,
    S_H_RD,
    S_H_CHK,
    S_F_CHK1,
    S_F_CHK2,
    S_F_RNX,
    S_F_WNX,
    S_U_CHK,
    S_RESP
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_INIT_HEAD,
    DP_INIT_END,
    DP_ACCEPT,
    DP_STEP,
    DP_SPLIT,
    DP_RD_NX,
    DP_WR_NX,
    DP_WR_NODE,
    DP_HINT_RD,
    DP_SET_HINT,
    DP_F_LATCH,
    DP_F_WRP,
    DP_USAGE,
    DP_PUSH
  } dp_op_e;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       size_ok;
    logic       free_ok;
    logic       last;
    logic       fit;
    logic       big;
    logic       link_ok;
    logic       at_hint;
    logic       clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/core/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/ffha_dp.sv
// Datapath of the heap allocator: header store, list walk registers, hint and result words.
// Depends on ffha_pkg and ffha_ram.
`default_nettype none
module ffha_dp import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_op_e      op_i,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire in_t         in_data_i,
  output dp_stat_t         stat_o,
  output out_t             out_data_o
);

  localparam int Depth = HEAP_BYTES / ALIGN_BYTES;
  localparam int IW    = $clog2(Depth);
  localparam int WW    = IW + 1;
  localparam int TW    = WW + 1;
  localparam int W     = IW + IW + WW;

  logic [12:0]   region_q;
  logic [IW-1:0] clr_q, hint_q, node_q, t_q, nx_q, lk_q, hp_q;
  logic [WW-1:0] hu_q, steps_q;
  logic [10:0]   sum_q;
  logic [12:0]   size_q;
  logic [11:0]   addr_q;
  out_t          res_q, out_q;

  logic          re, we;
  logic [IW-1:0] raddr, waddr;
  logic [W-1:0]  wdata, rdata;
  logic [IW-1:0] rd_prev, rd_next;
  logic [WW-1:0] rd_used;
  logic [31:0]   r_words, n_b, acc_b;
  logic [IW-1:0] e_idx, n_idx, acc_idx, t_idx;
  logic [TW-1:0] top, gap;
  logic [11:0]   need_w;
  logic [1:0]    acc_stat;

  ffha_ram #(.Width(W), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_prev = rdata[W-1 -: IW];
  assign rd_next = rdata[WW+IW-1 -: IW];
  assign rd_used = rdata[WW-1:0];

  always_comb begin
    r_words = {21'd0, region_q[12:2]};
    if (r_words > 32'(Depth)) begin
      r_words = 32'(Depth);
    end
    if (r_words < 32'(MIN_REGION_W)) begin
      r_words = 32'(MIN_REGION_W);
    end
  end

  assign e_idx   = IW'(r_words - 32'(HDR_WORDS));
  assign n_b     = {20'd0, addr_q} - 32'(HDR_BYTES);
  assign n_idx   = IW'(n_b >> 2);
  assign acc_b   = {20'd0, in_data_i.address} - 32'(HDR_BYTES);
  assign acc_idx = (in_data_i.command == CMD_ALLOC) ? hint_q :
                   (in_data_i.command == CMD_FREE)  ? IW'(acc_b >> 2) : '0;
  assign acc_stat = (in_data_i.command == CMD_ALLOC) ? STAT_OOM :
                    (in_data_i.command == CMD_FREE)  ? STAT_BAD_FREE : STAT_DONE;
  assign top     = TW'(node_q) + TW'(rd_used);
  assign t_idx   = IW'(top);
  assign gap     = (TW'(rd_next) > top) ? TW'(rd_next) - top : '0;
  assign need_w  = 12'((14'(size_q) + 14'(HDR_BYTES + ALIGN_BYTES - 1)) >> 2);

  always_comb begin
    stat_o          = '0;
    stat_o.in_cmd   = in_data_i.command;
    stat_o.size_ok  = {19'd0, size_q} <= 32'(HEAP_BYTES);
    stat_o.free_ok  = (addr_q >= 12'(HDR_BYTES)) && (n_b[1:0] == 2'b00) && (n_b != 32'd0)
                      && ((n_b >> 2) < (r_words - 32'(HDR_WORDS)));
    stat_o.last     = (rd_next == '0) || (steps_q == WW'(Depth));
    stat_o.fit      = 32'(gap) >= 32'(need_w);
    stat_o.big      = gap > TW'(HDR_WORDS);
    stat_o.link_ok  = rd_next == n_idx;
    stat_o.at_hint  = node_q == hint_q;
    stat_o.clr_last = clr_q == IW'(Depth - 1);
  end

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (op_i)
      DP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      DP_INIT_HEAD: begin
        we    = 1'b1;
        wdata = {{IW{1'b0}}, e_idx, WW'(HDR_WORDS)};
      end
      DP_INIT_END: begin
        we    = 1'b1;
        waddr = e_idx;
        wdata = {{IW{1'b0}}, {IW{1'b0}}, WW'(HDR_WORDS)};
      end
      DP_ACCEPT: begin
        re    = 1'b1;
        raddr = acc_idx;
      end
      DP_STEP: begin
        re    = 1'b1;
        raddr = rd_next;
      end
      DP_SPLIT: begin
        we    = 1'b1;
        waddr = t_idx;
        wdata = {node_q, rd_next, WW'(need_w)};
      end
      DP_RD_NX: begin
        re    = 1'b1;
        raddr = nx_q;
      end
      DP_WR_NX: begin
        we    = 1'b1;
        waddr = nx_q;
        wdata = {lk_q, rd_next, rd_used};
      end
      DP_WR_NODE: begin
        we    = 1'b1;
        waddr = node_q;
        wdata = {hp_q, t_q, hu_q};
      end
      DP_HINT_RD: begin
        re    = 1'b1;
        raddr = node_q;
      end
      DP_F_LATCH: begin
        re    = 1'b1;
        raddr = rd_prev;
      end
      DP_F_WRP: begin
        we    = 1'b1;
        waddr = lk_q;
        wdata = {rd_prev, nx_q, rd_used};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= 13'(REGION_RESET);
      clr_q    <= '0;
      hint_q   <= '0;
    end else if (cfg_we_i) begin
      region_q <= cfg_data_i;
      clr_q    <= '0;
    end else begin
      case (op_i)
        DP_CLEAR:     clr_q  <= clr_q + 1'b1;
        DP_INIT_HEAD: hint_q <= '0;
        DP_SET_HINT:  hint_q <= node_q;
        DP_F_WRP: begin
          if (lk_q < hint_q) begin
            hint_q <= lk_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      DP_ACCEPT: begin
        size_q  <= in_data_i.request_size;
        addr_q  <= in_data_i.address;
        node_q  <= (in_data_i.command == CMD_ALLOC) ? hint_q : '0;
        steps_q <= '0;
        sum_q   <= '0;
        res_q   <= {acc_stat, 38'd0};
      end
      DP_STEP: begin
        node_q  <= rd_next;
        steps_q <= steps_q + 1'b1;
        sum_q   <= sum_q + 11'(gap);
      end
      DP_SPLIT: begin
        t_q  <= t_idx;
        nx_q <= rd_next;
        lk_q <= t_idx;
        hp_q <= rd_prev;
        hu_q <= rd_used;
      end
      DP_WR_NODE: begin
        res_q <= {STAT_DONE, {10'(32'(t_q) + 32'(HDR_WORDS)), 2'b00},
                  res_q.used_bytes, res_q.free_bytes};
      end
      DP_HINT_RD: steps_q <= '0;
      DP_F_LATCH: begin
        lk_q <= rd_prev;
        nx_q <= rd_next;
      end
      DP_F_WRP: res_q.status <= STAT_DONE;
      DP_USAGE: begin
        res_q <= {res_q.status, res_q.block_address,
                  {11'(r_words - 32'(sum_q)), 2'b00}, {sum_q, 2'b00}};
      end
      DP_PUSH: out_q <= res_q;
      default: begin
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

### rtl/core/ffha_ctrl.sv
// Controller of the heap allocator: sequences clearing, list walks, splits and frees,
// and owns both handshakes. Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl import ffha_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire logic     cfg_we_i,
  input  wire dp_stat_t stat_i,
  output dp_op_e        op_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;
  logic   push;

  assign push = (state_q == S_RESP) && (!valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:     if (stat_i.clr_last) state_d = S_INIT_HEAD;
      S_INIT_HEAD: state_d = S_INIT_END;
      S_INIT_END:  state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          case (stat_i.in_cmd)
            CMD_ALLOC: state_d = S_A_CHK;
            CMD_FREE:  state_d = S_F_CHK1;
            CMD_USAGE: state_d = S_U_CHK;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_A_CHK: begin
        if (!stat_i.size_ok || stat_i.last) begin
          state_d = S_RESP;
        end else if (stat_i.fit) begin
          state_d = S_A_RNX;
        end
      end
      S_A_RNX:   state_d = S_A_WNX;
      S_A_WNX:   state_d = S_A_WNODE;
      S_A_WNODE: state_d = stat_i.at_hint ? S_H_RD : S_RESP;
      S_H_RD:    state_d = S_H_CHK;
      S_H_CHK:   if (stat_i.last || stat_i.big) state_d = S_RESP;
      S_F_CHK1:  state_d = stat_i.free_ok ? S_F_CHK2 : S_RESP;
      S_F_CHK2:  state_d = stat_i.link_ok ? S_F_RNX : S_RESP;
      S_F_RNX:   state_d = S_F_WNX;
      S_F_WNX:   state_d = S_RESP;
      S_U_CHK:   if (stat_i.last) state_d = S_RESP;
      S_RESP:    if (push) state_d = S_IDLE;
      default:   state_d = S_CLEAR;
    endcase
    if (cfg_we_i) begin
      state_d = S_CLEAR;
    end
  end

  always_comb begin
    op_o = DP_NOP;
    case (state_q)
      S_CLEAR:     op_o = DP_CLEAR;
      S_INIT_HEAD: op_o = DP_INIT_HEAD;
      S_INIT_END:  op_o = DP_INIT_END;
      S_IDLE:      if (in_valid_i) op_o = DP_ACCEPT;
      S_A_CHK: begin
        if (stat_i.size_ok && !stat_i.last) begin
          op_o = stat_i.fit ? DP_SPLIT : DP_STEP;
        end
      end
      S_A_RNX:   op_o = DP_RD_NX;
      S_A_WNX:   op_o = DP_WR_NX;
      S_A_WNODE: op_o = DP_WR_NODE;
      S_H_RD:    op_o = DP_HINT_RD;
      S_H_CHK:   op_o = (stat_i.last || stat_i.big) ? DP_SET_HINT : DP_STEP;
      S_F_CHK1:  if (stat_i.free_ok) op_o = DP_F_LATCH;
      S_F_CHK2:  if (stat_i.link_ok) op_o = DP_F_WRP;
      S_F_RNX:   op_o = DP_RD_NX;
      S_F_WNX:   op_o = DP_WR_NX;
      S_U_CHK:   op_o = stat_i.last ? DP_USAGE : DP_STEP;
      S_RESP:    if (push) op_o = DP_PUSH;
      default:   op_o = DP_NOP;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (push) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = valid_q;

  a_cfg_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == S_CLEAR)
    else $error("region write did not start a clearing pass");

  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_o == DP_PUSH) |-> (!valid_q || !out_stall_i))
    else $error("result pushed over a stalled word");

  a_accept_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cfg_we_i) |=> (state_q != S_IDLE))
    else $error("accepted word produced no work");

endmodule
`default_nettype wire

### rtl/core/first_fit_heap_allocator.sv
// After acceptance, an allocation walks the list from the hint past nodes until one fits, and
// splits that node; if it was the hint, the hint moves on past further nodes. A free checks
// the address and the link, then rewrites both neighbours; usage walks the whole list. One
// word at a time: the next word is accepted only once the result is issued. The header store
// is read one header per cycle. Reset and every region write run a clearing pass, stall high.
// Top level of the heap allocator. Depends on ffha_pkg, ffha_ctrl and ffha_dp.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [12:0] cfg_data_i
);

  dp_stat_t stat;
  dp_op_e   op;
  logic     cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we),
    .stat_i      (stat),
    .op_o        (op)
  );

  ffha_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
